FILE: rtl/core/ortra_pkg.sv
// Shared types, register codes and reset values for the over-temperature relay alarm.
`timescale 1ns / 1ps
package ortra_pkg;

  localparam int TIMER_WIDTH_DEF = 17;

  localparam int TEMP_W    = 18;
  localparam int HYST_W    = 14;
  localparam int SECONDS_W = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 18;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  localparam logic signed [TEMP_W-1:0]  AC_LIMIT_RST   = 18'sd32000;
  localparam logic signed [TEMP_W-1:0]  AMB_LIMIT_RST  = 18'sd32000;
  localparam logic [HYST_W-1:0]         HYST_RST       = 14'd1000;
  localparam logic [SECONDS_W-1:0]      REALERT_RST    = 17'd900;
  localparam logic [SECONDS_W-1:0]      RESTORE_RST    = 17'd3600;
  localparam logic [SECONDS_W-1:0]      PAUSE_RST      = 17'd900;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AC_LIMIT  = 3'd0,
    REG_AMB_LIMIT = 3'd1,
    REG_HYST      = 3'd2,
    REG_REALERT   = 3'd3,
    REG_RESTORE   = 3'd4,
    REG_PAUSE     = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [TEMP_W-1:0] ac_limit;
    logic signed [TEMP_W-1:0] amb_limit;
    logic [HYST_W-1:0]        hysteresis;
    logic [SECONDS_W-1:0]     realert_seconds;
    logic [SECONDS_W-1:0]     restore_seconds;
    logic [SECONDS_W-1:0]     pause_seconds;
  } cfg_t;

  typedef struct packed {
    logic                     sample_valid;
    logic signed [TEMP_W-1:0] ac_temp;
    logic signed [TEMP_W-1:0] amb_temp;
    logic                     button_press;
    logic                     flag_clear;
  } tick_t;

  // Single-bit state flags of the alarm.
  typedef struct packed {
    logic paused;
    logic alert_sent;
    logic ever_notified;
    logic relay1;
    logic relay2;
  } flags_t;

  typedef struct packed {
    logic                 relay1_level;
    logic                 relay2_level;
    logic                 alert_pulse;
    logic                 alert_urgent;
    logic                 recovery_pulse;
    logic                 paused_out;
    logic [SECONDS_W-1:0] pause_left;
  } result_t;

endpackage

FILE: rtl/core/ortra_tick_logic.sv
// Combinational next-state and result logic for one one-second tick.
`timescale 1ns / 1ps
module ortra_tick_logic #(
  parameter int TIMER_WIDTH = ortra_pkg::TIMER_WIDTH_DEF
) (
  input  ortra_pkg::cfg_t           cfg,
  input  ortra_pkg::tick_t          tick,
  input  ortra_pkg::flags_t         flags,
  input  logic [TIMER_WIDTH-1:0]    since_notice,
  input  logic [TIMER_WIDTH-1:0]    pause_elapsed,
  output ortra_pkg::flags_t         flags_nxt,
  output logic [TIMER_WIDTH-1:0]    since_notice_nxt,
  output logic [TIMER_WIDTH-1:0]    pause_elapsed_nxt,
  output ortra_pkg::result_t        result
);
  import ortra_pkg::*;

  // Common width for comparing the timers against the 17-bit intervals.
  localparam int CW = (TIMER_WIDTH > SECONDS_W) ? TIMER_WIDTH : SECONDS_W;
  localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

  logic [TIMER_WIDTH-1:0] since_inc;
  logic [TIMER_WIDTH-1:0] elapsed_inc;
  logic                   over_limit;
  logic                   below_band;
  logic signed [TEMP_W:0] ac_low;
  logic signed [TEMP_W:0] amb_low;
  logic [CW-1:0]          left_full;

  assign since_inc   = (since_notice == TMAX) ? TMAX : since_notice + 1'b1;
  assign elapsed_inc = (pause_elapsed == TMAX) ? TMAX : pause_elapsed + 1'b1;

  assign ac_low  = {cfg.ac_limit[TEMP_W-1], cfg.ac_limit}
                 - $signed({{(TEMP_W-HYST_W+1){1'b0}}, cfg.hysteresis});
  assign amb_low = {cfg.amb_limit[TEMP_W-1], cfg.amb_limit}
                 - $signed({{(TEMP_W-HYST_W+1){1'b0}}, cfg.hysteresis});

  assign over_limit = (tick.ac_temp > cfg.ac_limit) || (tick.amb_temp > cfg.amb_limit);
  assign below_band = ($signed({tick.ac_temp[TEMP_W-1], tick.ac_temp}) < ac_low)
                   && ($signed({tick.amb_temp[TEMP_W-1], tick.amb_temp}) < amb_low);

  always_comb begin
    flags_nxt            = flags;
    since_notice_nxt     = since_inc;
    pause_elapsed_nxt    = pause_elapsed;
    result               = '0;
    left_full            = '0;

    if (tick.flag_clear) begin
      flags_nxt.alert_sent = 1'b0;
    end

    if (tick.button_press) begin
      flags_nxt.paused = !flags.paused;
      if (!flags.paused) begin
        pause_elapsed_nxt = '0;
      end
      flags_nxt.relay1 = 1'b1;
      flags_nxt.relay2 = 1'b1;
    end else if (flags.paused) begin
      if (CW'(elapsed_inc) >= CW'(cfg.pause_seconds)) begin
        flags_nxt.paused  = 1'b0;
        pause_elapsed_nxt = '0;
      end else begin
        pause_elapsed_nxt = elapsed_inc;
      end
    end else if (tick.sample_valid) begin
      if (over_limit) begin
        flags_nxt.relay1 = 1'b0;
        flags_nxt.relay2 = 1'b0;
        if (!flags_nxt.alert_sent) begin
          flags_nxt.alert_sent    = 1'b1;
          flags_nxt.ever_notified = 1'b1;
          since_notice_nxt        = '0;
          result.alert_pulse      = 1'b1;
        end else if (CW'(since_inc) > CW'(cfg.realert_seconds)) begin
          since_notice_nxt    = '0;
          result.alert_pulse  = 1'b1;
          result.alert_urgent = 1'b1;
        end
      end else if (below_band) begin
        if (flags_nxt.alert_sent) begin
          flags_nxt.alert_sent    = 1'b0;
          flags_nxt.ever_notified = 1'b1;
          since_notice_nxt        = '0;
          result.recovery_pulse   = 1'b1;
          flags_nxt.relay1        = 1'b1;
          flags_nxt.relay2        = 1'b0;
        end
        if (flags_nxt.ever_notified
            && (CW'(since_notice_nxt) > CW'(cfg.restore_seconds))) begin
          flags_nxt.relay1 = 1'b1;
          flags_nxt.relay2 = 1'b1;
        end
      end
    end

    if (flags_nxt.paused && (CW'(pause_elapsed_nxt) < CW'(cfg.pause_seconds))) begin
      left_full = CW'(cfg.pause_seconds) - CW'(pause_elapsed_nxt);
    end

    result.relay1_level = flags_nxt.relay1;
    result.relay2_level = flags_nxt.relay2;
    result.paused_out   = flags_nxt.paused;
    result.pause_left   = left_full[SECONDS_W-1:0];
  end

endmodule

FILE: rtl/core/over_temperature_relay_alarm_core.sv
// Top level of the over-temperature relay alarm: stream ports, registers and state.
`timescale 1ns / 1ps
// A request accepted into the input register moves to the result register once
//   that register is free or draining, and is offered on out_tvalid from then on.
// Throughput: one request per cycle while out_tready is high; a new request is taken
//   while a result waits on out_tready only if the input register is empty.
// Reset: synchronous on rst_n low; configuration registers take their defaults,
//   relays high, pause, alert and notice state cleared, both stream stages empty.
module over_temperature_relay_alarm_core #(
  parameter int TIMER_WIDTH = ortra_pkg::TIMER_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [ortra_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ortra_pkg::CFG_DAT_W-1:0]   cfg_data,
  // Input stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // in_tdata from bit 0: ac_temp[17:0], amb_temp[35:18], button_press[36],
  // flag_clear[37], zero fill [39:38].
  input  logic [ortra_pkg::IN_DATA_W-1:0]   in_tdata,
  // in_tuser: sample_valid[0].
  input  logic                              in_tuser,
  // Result stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata from bit 0: relay1_level[0], relay2_level[1], alert_pulse[2],
  // alert_urgent[3], recovery_pulse[4], paused_out[5], pause_left[22:6],
  // zero fill [23].
  output logic [ortra_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import ortra_pkg::*;

  // Configuration registers.
  cfg_t cfg_r, cfg_nxt;

  // Input register: one tick request waiting for the processing edge.
  logic  in_valid_r, in_valid_nxt;
  tick_t in_item_r, in_item_nxt;

  // Alarm state.
  flags_t                 flags_r, flags_nxt;
  logic [TIMER_WIDTH-1:0] since_r, since_nxt;
  logic [TIMER_WIDTH-1:0] elapsed_r, elapsed_nxt;

  // Result register.
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r, out_res_nxt;

  tick_t   in_item;
  flags_t  flags_calc;
  logic [TIMER_WIDTH-1:0] since_calc;
  logic [TIMER_WIDTH-1:0] elapsed_calc;
  result_t res_calc;
  logic    advance;

  // The buffered request moves on whenever the result register is free or draining.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  assign in_item.sample_valid = in_tuser;
  assign in_item.ac_temp      = $signed(in_tdata[TEMP_W-1:0]);
  assign in_item.amb_temp     = $signed(in_tdata[2*TEMP_W-1:TEMP_W]);
  assign in_item.button_press = in_tdata[2*TEMP_W];
  assign in_item.flag_clear   = in_tdata[2*TEMP_W+1];

  ortra_tick_logic #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_tick (
    .cfg               (cfg_r),
    .tick              (in_item_r),
    .flags             (flags_r),
    .since_notice      (since_r),
    .pause_elapsed     (elapsed_r),
    .flags_nxt         (flags_calc),
    .since_notice_nxt  (since_calc),
    .pause_elapsed_nxt (elapsed_calc),
    .result            (res_calc)
  );

  // Register writes; indexes past the list are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_AC_LIMIT:  cfg_nxt.ac_limit        = $signed(cfg_data[TEMP_W-1:0]);
        REG_AMB_LIMIT: cfg_nxt.amb_limit       = $signed(cfg_data[TEMP_W-1:0]);
        REG_HYST:      cfg_nxt.hysteresis      = cfg_data[HYST_W-1:0];
        REG_REALERT:   cfg_nxt.realert_seconds = cfg_data[SECONDS_W-1:0];
        REG_RESTORE:   cfg_nxt.restore_seconds = cfg_data[SECONDS_W-1:0];
        REG_PAUSE:     cfg_nxt.pause_seconds   = cfg_data[SECONDS_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  // State advances only on processing; stream stages also load and drain on handshakes.
  always_comb begin
    in_valid_nxt  = in_valid_r;
    in_item_nxt   = in_item_r;
    flags_nxt     = flags_r;
    since_nxt     = since_r;
    elapsed_nxt   = elapsed_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      flags_nxt     = flags_calc;
      since_nxt     = since_calc;
      elapsed_nxt   = elapsed_calc;
      out_valid_nxt = 1'b1;
      out_res_nxt   = res_calc;
      in_valid_nxt  = 1'b0;
    end
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
      in_item_nxt  = in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ac_limit        <= AC_LIMIT_RST;
      cfg_r.amb_limit       <= AMB_LIMIT_RST;
      cfg_r.hysteresis      <= HYST_RST;
      cfg_r.realert_seconds <= REALERT_RST;
      cfg_r.restore_seconds <= RESTORE_RST;
      cfg_r.pause_seconds   <= PAUSE_RST;
      in_valid_r            <= 1'b0;
      out_valid_r           <= 1'b0;
      flags_r.paused        <= 1'b0;
      flags_r.alert_sent    <= 1'b0;
      flags_r.ever_notified <= 1'b0;
      flags_r.relay1        <= 1'b1;
      flags_r.relay2        <= 1'b1;
      since_r               <= '0;
      elapsed_r             <= '0;
    end else begin
      cfg_r       <= cfg_nxt;
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      flags_r     <= flags_nxt;
      since_r     <= since_nxt;
      elapsed_r   <= elapsed_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    in_item_r <= in_item_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.pause_left, out_res_r.paused_out,
                       out_res_r.recovery_pulse, out_res_r.alert_urgent,
                       out_res_r.alert_pulse, out_res_r.relay2_level,
                       out_res_r.relay1_level};

endmodule

FILE: rtl/core/ortra_checker.sv
// Port-level assertions for the over-temperature relay alarm, bound to the top level.
`timescale 1ns / 1ps
module ortra_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ortra_pkg::OUT_DATA_W-1:0] out_tdata
);
  import ortra_pkg::*;

  // An urgent flag only ever rides on an issued alert.
  a_urgent_needs_alert: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> out_tdata[2])
    else $error("urgent flag without alert pulse");

  // An alert and a recovery notice never come from the same tick.
  a_alert_recovery_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[2] && out_tdata[4]))
    else $error("alert and recovery in one result");

  // An alert tick always drives both relays low; a recovery leaves relay one high.
  a_relays_follow_notice: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[2] || (!out_tdata[0] && !out_tdata[1]))
                && (!out_tdata[4] || out_tdata[0]))
    else $error("relay levels disagree with notice");

  // Remaining pause time is shown only while paused.
  a_left_only_paused: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[22:6] != 17'd0) |-> out_tdata[5])
    else $error("pause time left while not paused");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind over_temperature_relay_alarm_core ortra_checker u_ortra_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: sim/tb_over_temperature_relay_alarm_core.sv
// Self-checking testbench for the over-temperature relay alarm core.
`timescale 1ns / 1ps
module tb_over_temperature_relay_alarm_core;
  import ortra_pkg::*;

  // The alarm timers saturate at the top of their width.
  localparam int TIMER_TOP      = (1 << TIMER_WIDTH_DEF) - 1;
  localparam int TEMP_LO        = -55000;
  localparam int TEMP_HI        = 125000;
  // Rows of the directed table from this index on run with one-second intervals.
  localparam int DIR_SPLIT      = 16;
  localparam int DIR_ROWS       = 25;
  localparam int PHASES         = 6;
  localparam int TICKS_PER_PHASE = 170;
  // The receiver holds off this long once, so that both stream stages fill up.
  localparam int HOLD_OFF       = 300;
  localparam int HOLD_AT_TICK   = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  // How the random temperatures drift for a run of ticks.
  typedef enum int {
    TREND_HOT,
    TREND_COOL,
    TREND_NEAR
  } trend_e;

  // One line of the directed table: the tick, and its outputs where typed in.
  typedef struct packed {
    tick_t   tick;
    logic    typed;
    result_t want;
  } dir_row_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_DAT_W-1:0] cfg_data   = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  // in_tdata from bit 0: ac_temp, amb_temp, button_press, flag_clear, zero fill.
  logic [IN_DATA_W-1:0] in_tdata   = '0;
  // in_tuser: sample_valid.
  logic                 in_tuser   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // out_tdata from bit 0: relay1_level, relay2_level, alert_pulse, alert_urgent,
  // recovery_pulse, paused_out, pause_left, zero fill.
  logic [OUT_DATA_W-1:0] out_tdata;

  // Alarm settings as the block should hold them.
  int          lim_ac    = AC_LIMIT_RST;
  int          lim_amb   = AMB_LIMIT_RST;
  int          hyst_md   = HYST_RST;
  int unsigned realert_s = REALERT_RST;
  int unsigned restore_s = RESTORE_RST;
  int unsigned pause_s   = PAUSE_RST;

  // Alarm state as the block should hold it.
  bit          m_paused        = 1'b0;
  int unsigned m_pause_elapsed = 0;
  bit          m_alert_sent    = 1'b0;
  bit          m_ever_notified = 1'b0;
  int unsigned m_since_notice  = 0;
  bit          m_relay1        = 1'b1;
  bit          m_relay2        = 1'b1;

  // Outputs of accepted requests, oldest first, still to come out of the block.
  result_t     outputs_due[$];
  dir_row_t    dir_tab[DIR_ROWS];

  int errors          = 0;
  int ticks_sent      = 0;
  int results_checked = 0;
  int quiet_cycles    = 0;
  int burst_left      = 0;
  int n_alert         = 0;
  int n_urgent        = 0;
  int n_recovery      = 0;
  int n_pause         = 0;

  over_temperature_relay_alarm_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  function automatic int unsigned sat_inc(int unsigned v);
    return (v >= TIMER_TOP) ? TIMER_TOP : v + 1;
  endfunction

  // Advances the alarm by one second and returns what it shows after the tick.
  // The clear of the alert flag and the notice timer come first; then the tick
  // is either a button press, a second of pause, or a look at the samples.
  function automatic result_t step_alarm(tick_t t);
    result_t r;
    int      ac;
    int      amb;
    ac  = $signed(t.ac_temp);
    amb = $signed(t.amb_temp);
    r   = '0;
    if (t.flag_clear) begin
      m_alert_sent = 1'b0;
    end
    m_since_notice = sat_inc(m_since_notice);
    if (t.button_press) begin
      m_paused = !m_paused;
      if (m_paused) begin
        m_pause_elapsed = 0;
      end
      m_relay1 = 1'b1;
      m_relay2 = 1'b1;
    end else if (m_paused) begin
      m_pause_elapsed = sat_inc(m_pause_elapsed);
      if (m_pause_elapsed >= pause_s) begin
        m_paused        = 1'b0;
        m_pause_elapsed = 0;
      end
    end else if (t.sample_valid) begin
      if (ac > lim_ac || amb > lim_amb) begin
        // Over a limit: relays close, and a notice goes out when one is due.
        m_relay1 = 1'b0;
        m_relay2 = 1'b0;
        if (!m_alert_sent) begin
          m_alert_sent    = 1'b1;
          m_ever_notified = 1'b1;
          m_since_notice  = 0;
          r.alert_pulse   = 1'b1;
        end else if (m_since_notice > realert_s) begin
          m_since_notice = 0;
          r.alert_pulse  = 1'b1;
          r.alert_urgent = 1'b1;
        end
      end else if (ac < lim_ac - hyst_md && amb < lim_amb - hyst_md) begin
        // Clear of the hysteresis band: one recovery notice, relay1 first,
        // both relays once the restore interval has run out.
        if (m_alert_sent) begin
          m_alert_sent     = 1'b0;
          m_ever_notified  = 1'b1;
          m_since_notice   = 0;
          r.recovery_pulse = 1'b1;
          m_relay1         = 1'b1;
          m_relay2         = 1'b0;
        end
        if (m_ever_notified && m_since_notice > restore_s) begin
          m_relay1 = 1'b1;
          m_relay2 = 1'b1;
        end
      end
    end
    r.relay1_level = m_relay1;
    r.relay2_level = m_relay2;
    r.paused_out   = m_paused;
    if (m_paused && m_pause_elapsed < pause_s) begin
      r.pause_left = SECONDS_W'(pause_s - m_pause_elapsed);
    end
    return r;
  endfunction

  // Builds a table line. The flags are relay1, relay2, alert, urgent, recovery
  // and paused, from the left.
  function automatic dir_row_t row(bit v, int ac, int amb, bit press, bit clr,
                                   bit typed, bit [5:0] flags, int left);
    dir_row_t d;
    d.tick.sample_valid = v;
    d.tick.ac_temp      = ac[TEMP_W-1:0];
    d.tick.amb_temp     = amb[TEMP_W-1:0];
    d.tick.button_press = press;
    d.tick.flag_clear   = clr;
    d.typed             = typed;
    d.want              = result_t'({flags, left[SECONDS_W-1:0]});
    return d;
  endfunction

  function automatic int fit_temp(int v);
    return (v < TEMP_LO) ? TEMP_LO : (v > TEMP_HI) ? TEMP_HI : v;
  endfunction

  // A reading around a limit, now and then right on the limit or on the edge
  // of the hysteresis band, now and then anywhere in the probe range.
  function automatic int near_temp(int lim);
    int span;
    int v;
    span = hyst_md + 3000;
    case ($urandom_range(0, 7))
      0, 1:    v = int'($urandom_range(0, TEMP_HI - TEMP_LO)) + TEMP_LO;
      2:       v = lim;
      3:       v = lim - hyst_md;
      default: v = lim + int'($urandom_range(0, 2 * span)) - span;
    endcase
    return fit_temp(v);
  endfunction

  function automatic tick_t random_tick(trend_e tr);
    tick_t t;
    int    ac;
    int    amb;
    ac  = near_temp(lim_ac);
    amb = near_temp(lim_amb);
    case (tr)
      TREND_HOT: begin
        if ($urandom_range(0, 1) == 1) begin
          ac = lim_ac + 1 + int'($urandom_range(0, 5000));
        end else begin
          amb = lim_amb + 1 + int'($urandom_range(0, 5000));
        end
      end
      TREND_COOL: begin
        ac  = lim_ac - hyst_md - 1 - int'($urandom_range(0, 5000));
        amb = lim_amb - hyst_md - 1 - int'($urandom_range(0, 5000));
      end
      default: begin
      end
    endcase
    t.sample_valid = ($urandom_range(0, 9) != 0);
    t.ac_temp      = TEMP_W'(fit_temp(ac));
    t.amb_temp     = TEMP_W'(fit_temp(amb));
    t.button_press = ($urandom_range(0, 39) == 0);
    t.flag_clear   = ($urandom_range(0, 24) == 0);
    return t;
  endfunction

  // Writes one register and follows it in the predictor's settings.
  task automatic set_reg(cfg_reg_e idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DAT_W-1:0];
    @(posedge clk);
    case (idx)
      REG_AC_LIMIT:  lim_ac    = $signed(val[TEMP_W-1:0]);
      REG_AMB_LIMIT: lim_amb   = $signed(val[TEMP_W-1:0]);
      REG_HYST:      hyst_md   = val[HYST_W-1:0];
      REG_REALERT:   realert_s = val[SECONDS_W-1:0];
      REG_RESTORE:   restore_s = val[SECONDS_W-1:0];
      REG_PAUSE:     pause_s   = val[SECONDS_W-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic apply_settings(int acl, int ambl, int hy, int rea, int res, int pau);
    set_reg(REG_AC_LIMIT, acl);
    set_reg(REG_AMB_LIMIT, ambl);
    set_reg(REG_HYST, hy);
    set_reg(REG_REALERT, rea);
    set_reg(REG_RESTORE, res);
    set_reg(REG_PAUSE, pau);
    cfg_we <= 1'b0;
  endtask

  // Stops offering requests until every outstanding result has come back.
  // Each request yields exactly one result, so the block is idle afterwards.
  task automatic drain_outputs;
    in_tvalid <= 1'b0;
    while (outputs_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // The sender works in bursts; between most bursts in_tvalid drops for a random gap.
  task automatic sender_pace;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Offers one request and waits for it to be taken. in_tvalid stays high on
  // return, so back-to-back requests leave no hole.
  task automatic offer_tick(tick_t t, bit typed, result_t want);
    result_t r;
    in_tvalid <= 1'b1;
    in_tuser  <= t.sample_valid;
    in_tdata  <= {2'b00, t.flag_clear, t.button_press, t.amb_temp, t.ac_temp};
    do @(posedge clk); while (!in_tready);
    r = step_alarm(t);
    outputs_due.push_back(typed ? want : r);
    ticks_sent++;
    n_alert    += (r.alert_pulse && !r.alert_urgent);
    n_urgent   += r.alert_urgent;
    n_recovery += r.recovery_pulse;
    n_pause    += (t.button_press && r.paused_out);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic check_outputs(result_t want, logic [OUT_DATA_W-1:0] got);
    check_field("relay1_level", want.relay1_level, got[0]);
    check_field("relay2_level", want.relay2_level, got[1]);
    check_field("alert_pulse", want.alert_pulse, got[2]);
    check_field("alert_urgent", want.alert_urgent, got[3]);
    check_field("recovery_pulse", want.recovery_pulse, got[4]);
    check_field("paused_out", want.paused_out, got[5]);
    check_field("pause_left", want.pause_left, got[22:6]);
  endtask

  // Result side: every accepted result is compared with the oldest outstanding
  // request. The watchdog runs here too, counting cycles without any handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (out_tvalid && out_tready) begin
        if (outputs_due.size() == 0) begin
          $error("result %h arrived with no request outstanding", out_tdata);
          errors++;
        end else begin
          check_outputs(outputs_due.pop_front(), out_tdata);
          results_checked++;
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                 quiet_cycles, outputs_due.size());
        $display("tb_over_temperature_relay_alarm_core failed");
        $finish;
      end
    end
  end

  // Receiver: out_tready steps through four patterns, from always ready
  // through random and periodic stalls. Once, after HOLD_AT_TICK requests,
  // it holds off long enough for the block to fill and stall its input
  // while the sender keeps offering.
  initial begin
    int cyc;
    bit held;
    cyc  = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (!held && ticks_sent >= HOLD_AT_TICK) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end else begin
        case ((cyc / 97) % 4)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 1) == 1);
          2:       out_tready <= (cyc % 4 != 0);
          default: out_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Sender: directed table first, then random phases under several settings.
  initial begin
    tick_t  t;
    trend_e trend;
    int     trend_left;
    result_t none;
    none       = '0;
    trend      = TREND_NEAR;
    trend_left = 0;

    // Rows up to DIR_SPLIT run with the reset settings: limits 32000, band 1000,
    // pause 900. Typed rows can be read straight off the alarm rules.
    dir_tab[0]  = row(1, 20000, 20000, 0, 0, 1, 6'b110000, 0);     // quiet after reset
    dir_tab[1]  = row(1, 125000, -55000, 0, 0, 1, 6'b001000, 0);   // first alert
    dir_tab[2]  = row(1, -55000, 125000, 0, 0, 1, 6'b000000, 0);   // still hot, no repeat yet
    dir_tab[3]  = row(1, 31500, 31500, 0, 0, 1, 6'b000000, 0);     // inside the band
    dir_tab[4]  = row(1, 32000, 32000, 0, 0, 1, 6'b000000, 0);     // on the limit is not over
    dir_tab[5]  = row(1, 30999, 30999, 0, 0, 1, 6'b100010, 0);     // recovery notice
    dir_tab[6]  = row(0, 125000, 125000, 0, 0, 1, 6'b100000, 0);   // no sample, ignored
    dir_tab[7]  = row(1, -55000, -55000, 0, 0, 1, 6'b100000, 0);   // cool, restore not due
    dir_tab[8]  = row(1, 125000, 125000, 1, 0, 1, 6'b110001, 900); // pause starts
    dir_tab[9]  = row(1, 125000, 125000, 0, 0, 1, 6'b110001, 899); // paused, not monitored
    dir_tab[10] = row(0, 0, 0, 1, 1, 1, 6'b110000, 0);             // press ends the pause
    dir_tab[11] = row(1, 32001, 0, 0, 0, 1, 6'b001000, 0);         // just over on one probe
    dir_tab[12] = row(1, 0, 32001, 0, 1, 1, 6'b001000, 0);         // clear forces a new alert
    dir_tab[13] = row(1, 31000, 31000, 0, 0, 1, 6'b000000, 0);     // on the band edge
    dir_tab[14] = row(1, -54999, 30000, 0, 0, 1, 6'b100010, 0);    // recovery again
    dir_tab[15] = row(0, -1, -1, 0, 1, 0, 6'b000000, 0);           // lone clear
    // From here on every interval is one second.
    dir_tab[16] = row(1, 40000, 0, 0, 0, 1, 6'b001000, 0);         // alert
    dir_tab[17] = row(1, 40000, 0, 0, 0, 1, 6'b000000, 0);         // repeat not yet due
    dir_tab[18] = row(1, 0, 40000, 0, 0, 1, 6'b001100, 0);         // urgent repeat
    dir_tab[19] = row(1, 0, 0, 0, 0, 1, 6'b100010, 0);             // recovery, relay1 only
    dir_tab[20] = row(1, 0, 0, 0, 0, 1, 6'b100000, 0);             // restore not yet due
    dir_tab[21] = row(1, 0, 0, 0, 0, 1, 6'b110000, 0);             // both relays back
    dir_tab[22] = row(0, 0, 0, 1, 0, 1, 6'b110001, 1);             // pause starts
    dir_tab[23] = row(1, 125000, 125000, 0, 0, 1, 6'b110000, 0);   // pause runs out
    dir_tab[24] = row(1, 125000, 125000, 1, 1, 0, 6'b000000, 0);   // press, clear and heat

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == DIR_SPLIT) begin
        drain_outputs();
        apply_settings(32000, 32000, 1000, 1, 1, 1);
      end
      sender_pace();
      offer_tick(dir_tab[i].tick, dir_tab[i].typed, dir_tab[i].want);
    end

    // Random phases. The settings are changed only once the block has handed
    // back every result, which also gives the sender a full pause each time.
    for (int p = 0; p < PHASES; p++) begin
      drain_outputs();
      case (p)
        0: apply_settings(32000, 32000, 1000, 3, 6, 5);
        1: apply_settings(TEMP_LO, TEMP_LO, 0, 0, 0, 0);
        2: apply_settings(TEMP_HI, TEMP_HI, 10000, 86400, 86400, 86400);
        3: apply_settings(20000, -10000, 500, 10, 20, 8);
        4: apply_settings(int'($urandom_range(0, TEMP_HI - TEMP_LO)) + TEMP_LO,
                          int'($urandom_range(0, TEMP_HI - TEMP_LO)) + TEMP_LO,
                          $urandom_range(0, 10000), $urandom_range(0, 30),
                          $urandom_range(0, 30), $urandom_range(0, 30));
        default: apply_settings(32000, 32000, 1000, 900, 3600, 900);
      endcase
      for (int k = 0; k < TICKS_PER_PHASE; k++) begin
        // Temperatures follow a trend for a run of ticks, so that alerts
        // persist long enough for repeats, recoveries and restores.
        if (trend_left == 0) begin
          trend_left = $urandom_range(1, 30);
          trend = trend_e'($urandom_range(0, 2));
        end
        trend_left--;
        t = random_tick(trend);
        sender_pace();
        offer_tick(t, 1'b0, none);
      end
    end

    drain_outputs();
    repeat (8) @(posedge clk);

    $display("%0d requests under %0d register settings, %0d results checked",
             ticks_sent, PHASES + 2, results_checked);
    $display("seen: %0d first alerts, %0d urgent repeats, %0d recoveries, %0d pauses",
             n_alert, n_urgent, n_recovery, n_pause);
    if (errors == 0) begin
      $display("tb_over_temperature_relay_alarm_core passed");
    end else begin
      $display("tb_over_temperature_relay_alarm_core failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/ortra_pkg.sv
rtl/core/ortra_tick_logic.sv
rtl/core/over_temperature_relay_alarm_core.sv
rtl/core/ortra_checker.sv
sim/tb_over_temperature_relay_alarm_core.sv
